// File: rtl/rsn_pkg.sv
// shared types, widths and codes for the ray/sphere nearest-hit block
package rsn_pkg;

    localparam int NUM_SPHERES_DEF = 4;
    localparam int IMAGE_WIDTH_DEF = 640;

    // apb register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam logic [2:0] REG_CAM_X = 3'd0;
    localparam logic [2:0] REG_CAM_Y = 3'd1;
    localparam logic [2:0] REG_CAM_Z = 3'd2;
    localparam logic [2:0] REG_SCALE = 3'd3;
    localparam logic [2:0] REG_PLANE = 3'd4;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_TRACE = 1'b1;

    // datapath widths
    localparam int PROD_W = 96;   // products and the discriminant
    localparam int ROOT_W = 48;   // floor square root of the discriminant
    localparam int OPND_W = 64;   // multiplier operands

    localparam logic [7:0] WHITE = 8'hFF;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic        [15:0] r;
    } t_geom;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_paint;

endpackage

// File: rtl/rsn_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle, stops early
module rsn_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_go,
    input  logic signed [rsn_pkg::OPND_W-1:0]   i_mcand,
    input  logic signed [rsn_pkg::OPND_W-1:0]   i_mplier,
    output logic                                o_done,
    output logic signed [rsn_pkg::PROD_W-1:0]   o_prod
);
    import rsn_pkg::*;

    logic                r_busy;
    logic [PROD_W-1:0]   r_mc;
    logic [OPND_W-1:0]   r_mp;
    logic [PROD_W-1:0]   r_p;
    logic                r_neg;
    logic [OPND_W-1:0]   w_mag_mc;
    logic [OPND_W-1:0]   w_mag_mp;

    // operand magnitudes
    assign w_mag_mc = i_mcand[OPND_W-1]  ? OPND_W'(-i_mcand)  : OPND_W'(i_mcand);
    assign w_mag_mp = i_mplier[OPND_W-1] ? OPND_W'(-i_mplier) : OPND_W'(i_mplier);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_go) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_mp == '0)) begin
            r_busy <= 1'b0;
        end
    end

    // shift and add
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_mc  <= PROD_W'(w_mag_mc);
            r_mp  <= w_mag_mp;
            r_p   <= '0;
            r_neg <= i_mcand[OPND_W-1] ^ i_mplier[OPND_W-1];
        end else if (r_busy && (r_mp != '0)) begin
            if (r_mp[0]) begin
                r_p <= r_p + r_mc;
            end
            r_mc <= r_mc << 1;
            r_mp <= r_mp >> 1;
        end
    end

    assign o_done = r_busy && (r_mp == '0);
    assign o_prod = r_neg ? $signed(-r_p) : $signed(r_p);

endmodule

// File: rtl/rsn_sqrt.sv
// digit-by-digit floor square root, one root bit per cycle
module rsn_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [rsn_pkg::PROD_W-1:0]    i_rad,
    output logic                          o_done,
    output logic [rsn_pkg::ROOT_W-1:0]    o_root
);
    import rsn_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 3;

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [PROD_W-1:0]  r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [REM_W-1:0]   w_rem2;
    logic [REM_W-1:0]   w_trial;
    logic               w_fin;

    // bring down two radicand bits, try root*4+1
    assign w_rem2  = {r_rem[ROOT_W:0], r_rad[PROD_W-1 -: 2]};
    assign w_trial = REM_W'({r_root, 2'b01});
    assign w_fin   = r_busy && (r_cnt == CNT_W'(ROOT_W));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_fin) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // one digit per cycle
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy && !w_fin) begin
            r_rad <= r_rad << 2;
            if (w_rem2 >= w_trial) begin
                r_rem  <= w_rem2 - w_trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem2;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = w_fin;
    assign o_root = r_root;

endmodule

// File: rtl/rsn_store.sv
// sphere slot memories (geometry, paint) and per-slot valid flags
module rsn_store #(
    parameter  int NUM_SPHERES = rsn_pkg::NUM_SPHERES_DEF,
    localparam int SW = (NUM_SPHERES > 1) ? $clog2(NUM_SPHERES) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  logic [SW-1:0]          i_wr_addr,
    input  rsn_pkg::t_geom         i_wr_geom,
    input  rsn_pkg::t_paint        i_wr_paint,
    input  logic [SW-1:0]          i_geom_addr,
    output rsn_pkg::t_geom         o_geom,
    input  logic [SW-1:0]          i_paint_addr,
    output rsn_pkg::t_paint        o_paint,
    output logic [NUM_SPHERES-1:0] o_vld
);
    import rsn_pkg::*;

    t_geom                  mem_geom  [NUM_SPHERES];
    t_paint                 mem_paint [NUM_SPHERES];
    logic [NUM_SPHERES-1:0] r_vld;

    // geometry memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem_geom[i_wr_addr] <= i_wr_geom;
        end
        o_geom <= mem_geom[i_geom_addr];
    end

    // paint memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem_paint[i_wr_addr] <= i_wr_paint;
        end
        o_paint <= mem_paint[i_paint_addr];
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_vld = r_vld;

endmodule

// File: rtl/ray_sphere_nearest_hit.sv
// top level: camera registers, trace sequencer and root selection
//
// Load beats (i_mode 0) write one sphere slot and never raise busy, so loads
// may be issued back to back. A trace beat (i_mode 1) raises busy until its
// result is strobed on o_valid for one cycle; the receiver cannot stall it, so
// o_valid must be sampled on every clock. All products share one bit-serial
// multiplier that retires one multiplier bit per cycle. A trace first forms
// the ray direction and its squared length. Each valid slot is then fetched
// and takes nine products (the offset and radius products, the square of B
// and A times C), a square root unless the discriminant is negative, and a
// test of both roots. Invalid slots are skipped. On a miss the result is
// strobed from ST_FIN; on a hit it passes through ST_OUT, which reads the
// paint of the nearest slot.
module ray_sphere_nearest_hit #(
    parameter int NUM_SPHERES = rsn_pkg::NUM_SPHERES_DEF,
    parameter int IMAGE_WIDTH = rsn_pkg::IMAGE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_mode,
    input  logic [1:0]                   i_slot,
    input  logic signed [15:0]           i_center_x,
    input  logic signed [15:0]           i_center_y,
    input  logic signed [15:0]           i_center_z,
    input  logic [15:0]                  i_radius,
    input  logic [7:0]                   i_paint_red,
    input  logic [7:0]                   i_paint_green,
    input  logic [7:0]                   i_paint_blue,
    input  logic signed [11:0]           i_pixel_x,
    input  logic signed [11:0]           i_pixel_y,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic [1:0]                   o_hit_slot,
    output logic [7:0]                   o_out_red,
    output logic [7:0]                   o_out_green,
    output logic [7:0]                   o_out_blue,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rsn_pkg::ADDR_W-1:0]   paddr,
    input  logic [rsn_pkg::DATA_W-1:0]   pwdata,
    output logic [rsn_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import rsn_pkg::*;

    localparam int SW   = (NUM_SPHERES > 1) ? $clog2(NUM_SPHERES) : 1;
    localparam int KW   = $clog2(NUM_SPHERES + 1);
    localparam int D_W  = 30;
    localparam int O_W  = 17;
    localparam int A_W  = 60;
    localparam int B_W  = 48;
    localparam int C_W  = 40;
    localparam int N_W  = 50;
    localparam logic signed [63:0] IW64 = 64'(IMAGE_WIDTH);

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DIR  = 4'd1;
    localparam logic [3:0] ST_SEL  = 4'd2;
    localparam logic [3:0] ST_LD   = 4'd3;
    localparam logic [3:0] ST_MUL  = 4'd4;
    localparam logic [3:0] ST_SQ   = 4'd5;
    localparam logic [3:0] ST_R0   = 4'd6;
    localparam logic [3:0] ST_R1   = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    // product steps
    localparam logic [3:0] MS_BX = 4'd0;
    localparam logic [3:0] MS_BY = 4'd1;
    localparam logic [3:0] MS_BZ = 4'd2;
    localparam logic [3:0] MS_CX = 4'd3;
    localparam logic [3:0] MS_CY = 4'd4;
    localparam logic [3:0] MS_CZ = 4'd5;
    localparam logic [3:0] MS_CR = 4'd6;
    localparam logic [3:0] MS_BB = 4'd7;
    localparam logic [3:0] MS_AC = 4'd8;

    // accumulate codes
    localparam logic [1:0] OP_SET = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;

    logic signed [15:0]         r_cam_x, r_cam_y, r_cam_z;
    logic [15:0]                r_scale, r_plane;
    logic [3:0]                 r_state;
    logic [3:0]                 r_step;
    logic                       r_pend;
    logic [KW-1:0]              r_k;
    logic signed [D_W-1:0]      r_dx, r_dy, r_dz;
    logic signed [A_W-1:0]      r_a;
    logic signed [O_W-1:0]      r_ox, r_oy, r_oz;
    logic signed [B_W-1:0]      r_b;
    logic signed [C_W-1:0]      r_c;
    logic signed [PROD_W-1:0]   r_acc;
    logic [ROOT_W-1:0]          r_s;
    logic                       r_found;
    logic [SW-1:0]              r_best;
    logic signed [N_W-1:0]      r_bestn;
    logic                       r_ovld;
    logic                       r_hit;
    logic [1:0]                 r_hslot;
    logic [7:0]                 r_red, r_green, r_blue;

    logic                       w_cfg_wr;
    logic                       w_acc;
    logic                       w_ld_wr;
    t_geom                      w_wgeom;
    t_paint                     w_wpaint;
    t_geom                      w_geom;
    t_paint                     w_paint;
    logic [NUM_SPHERES-1:0]     w_vld;
    logic                       w_mgo, w_mdone;
    logic signed [OPND_W-1:0]   w_mc, w_mp;
    logic signed [PROD_W-1:0]   w_prod;
    logic [1:0]                 w_op;
    logic signed [PROD_W-1:0]   w_acc_nx;
    logic                       w_sgo, w_sdone;
    logic [ROOT_W-1:0]          w_root;
    logic signed [N_W-1:0]      w_n;
    logic                       w_take;

    // apb register file
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0;
            r_cam_y <= '0;
            r_cam_z <= '0;
            r_scale <= 16'd256;
            r_plane <= 16'd256;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_CAM_X: r_cam_x <= pwdata[15:0];
                REG_CAM_Y: r_cam_y <= pwdata[15:0];
                REG_CAM_Z: r_cam_z <= pwdata[15:0];
                REG_SCALE: r_scale <= pwdata[15:0];
                REG_PLANE: r_plane <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_CAM_X: prdata = DATA_W'(r_cam_x);
            REG_CAM_Y: prdata = DATA_W'(r_cam_y);
            REG_CAM_Z: prdata = DATA_W'(r_cam_z);
            REG_SCALE: prdata = DATA_W'(r_scale);
            REG_PLANE: prdata = DATA_W'(r_plane);
            default:   prdata = '0;
        endcase
    end

    // load beats write the slot store directly
    assign busy    = (r_state != ST_IDLE);
    assign w_acc   = start && !busy;
    assign w_ld_wr = w_acc && (i_mode == MODE_LOAD) && (32'(i_slot) < NUM_SPHERES);
    assign w_wgeom  = '{cx: i_center_x, cy: i_center_y, cz: i_center_z, r: i_radius};
    assign w_wpaint = '{red: i_paint_red, green: i_paint_green, blue: i_paint_blue};

    rsn_store #(.NUM_SPHERES(NUM_SPHERES)) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (w_ld_wr),
        .i_wr_addr    (SW'(i_slot)),
        .i_wr_geom    (w_wgeom),
        .i_wr_paint   (w_wpaint),
        .i_geom_addr  (r_k[SW-1:0]),
        .o_geom       (w_geom),
        .i_paint_addr (r_best),
        .o_paint      (w_paint),
        .o_vld        (w_vld)
    );

    // multiplier operand select
    always_comb begin
        w_mc = '0;
        w_mp = '0;
        w_op = OP_ADD;
        if (r_state == ST_DIR) begin
            unique case (r_step)
                MS_BX:   begin w_mc = 64'(r_dx); w_mp = 64'(r_dx); w_op = OP_SET; end
                MS_BY:   begin w_mc = 64'(r_dy); w_mp = 64'(r_dy); end
                default: begin w_mc = 64'(r_dz); w_mp = 64'(r_dz); end
            endcase
        end else begin
            unique case (r_step)
                MS_BX: begin w_mc = 64'(r_dx); w_mp = 64'(r_ox); w_op = OP_SET; end
                MS_BY: begin w_mc = 64'(r_dy); w_mp = 64'(r_oy); end
                MS_BZ: begin w_mc = 64'(r_dz); w_mp = 64'(r_oz); end
                MS_CX: begin w_mc = 64'(r_ox); w_mp = 64'(r_ox); w_op = OP_SET; end
                MS_CY: begin w_mc = 64'(r_oy); w_mp = 64'(r_oy); end
                MS_CZ: begin w_mc = 64'(r_oz); w_mp = 64'(r_oz); end
                MS_CR: begin
                    w_mc = $signed(64'(w_geom.r));
                    w_mp = $signed(64'(w_geom.r));
                    w_op = OP_SUB;
                end
                MS_BB: begin w_mc = 64'(r_b); w_mp = 64'(r_b); w_op = OP_SET; end
                default: begin w_mc = 64'(r_a); w_mp = 64'(r_c); w_op = OP_SUB; end
            endcase
        end
    end

    assign w_mgo = ((r_state == ST_DIR) || (r_state == ST_MUL)) && !r_pend;
    assign w_sgo = (r_state == ST_SQ) && !r_pend;

    rsn_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_mgo),
        .i_mcand  (w_mc),
        .i_mplier (w_mp),
        .o_done   (w_mdone),
        .o_prod   (w_prod)
    );

    rsn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_sgo),
        .i_rad   (r_acc),
        .o_done  (w_sdone),
        .o_root  (w_root)
    );

    // accumulator next value
    always_comb begin
        case (w_op)
            OP_SET:  w_acc_nx = w_prod;
            OP_SUB:  w_acc_nx = r_acc - w_prod;
            default: w_acc_nx = r_acc + w_prod;
        endcase
    end

    // candidate root -b+s then -b-s, hit when width*n > a
    assign w_n = (r_state == ST_R0) ? (-N_W'(r_b) + $signed(N_W'(r_s)))
                                    : (-N_W'(r_b) - $signed(N_W'(r_s)));
    assign w_take = ((64'(w_n) * IW64) > 64'(r_a)) && (!r_found || (w_n < r_bestn));

    // trace sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_pend  <= 1'b0;
            r_k     <= '0;
            r_found <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_ovld <= 1'b0;
            if (w_mgo || w_sgo) begin
                r_pend <= 1'b1;
            end else if (w_mdone || w_sdone) begin
                r_pend <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc && (i_mode == MODE_TRACE)) begin
                        r_state <= ST_DIR;
                        r_step  <= MS_BX;
                        r_k     <= '0;
                        r_found <= 1'b0;
                    end
                end
                ST_DIR: begin
                    if (w_mdone) begin
                        if (r_step == MS_BZ) begin
                            r_state <= (w_acc_nx == '0) ? ST_FIN : ST_SEL;
                        end else begin
                            r_step <= r_step + 4'd1;
                        end
                    end
                end
                ST_SEL: begin
                    if (r_k == KW'(NUM_SPHERES)) begin
                        r_state <= ST_FIN;
                    end else if (w_vld[r_k[SW-1:0]]) begin
                        r_state <= ST_LD;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                ST_LD: begin
                    r_state <= ST_MUL;
                    r_step  <= MS_BX;
                end
                ST_MUL: begin
                    if (w_mdone) begin
                        if (r_step == MS_AC) begin
                            if (w_acc_nx[PROD_W-1]) begin
                                r_k     <= r_k + KW'(1);
                                r_state <= ST_SEL;
                            end else begin
                                r_state <= ST_SQ;
                            end
                        end else begin
                            r_step <= r_step + 4'd1;
                        end
                    end
                end
                ST_SQ: begin
                    if (w_sdone) begin
                        r_state <= ST_R0;
                    end
                end
                ST_R0: begin
                    r_state <= ST_R1;
                    if (w_take) begin
                        r_found <= 1'b1;
                    end
                end
                ST_R1: begin
                    r_k     <= r_k + KW'(1);
                    r_state <= ST_SEL;
                    if (w_take) begin
                        r_found <= 1'b1;
                    end
                end
                ST_FIN: begin
                    if (r_found) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_ovld  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    r_ovld  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_acc && (i_mode == MODE_TRACE)) begin
            r_dx <= D_W'(i_pixel_x * $signed({1'b0, r_scale}));
            r_dy <= D_W'(i_pixel_y * $signed({1'b0, r_scale}));
            r_dz <= $signed(D_W'(r_plane * IMAGE_WIDTH));
        end
        if (w_mdone) begin
            r_acc <= w_acc_nx;
            if ((r_state == ST_DIR) && (r_step == MS_BZ)) begin
                r_a <= A_W'(w_acc_nx);
            end
            if ((r_state == ST_MUL) && (r_step == MS_BZ)) begin
                r_b <= B_W'(w_acc_nx);
            end
            if ((r_state == ST_MUL) && (r_step == MS_CR)) begin
                r_c <= C_W'(w_acc_nx);
            end
        end
        if (r_state == ST_LD) begin
            r_ox <= O_W'(r_cam_x) - O_W'(w_geom.cx);
            r_oy <= O_W'(r_cam_y) - O_W'(w_geom.cy);
            r_oz <= O_W'(r_cam_z) - O_W'(w_geom.cz);
        end
        if (w_sdone) begin
            r_s <= w_root;
        end
        if (((r_state == ST_R0) || (r_state == ST_R1)) && w_take) begin
            r_bestn <= w_n;
            r_best  <= r_k[SW-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && !r_found) begin
            r_hit   <= 1'b0;
            r_hslot <= '0;
            r_red   <= WHITE;
            r_green <= WHITE;
            r_blue  <= WHITE;
        end else if (r_state == ST_OUT) begin
            r_hit   <= 1'b1;
            r_hslot <= 2'(r_best);
            r_red   <= w_paint.red;
            r_green <= w_paint.green;
            r_blue  <= w_paint.blue;
        end
    end

    assign o_valid     = r_ovld;
    assign o_hit       = r_hit;
    assign o_hit_slot  = r_hslot;
    assign o_out_red   = r_red;
    assign o_out_green = r_green;
    assign o_out_blue  = r_blue;

endmodule

// File: rtl/rsn_check.sv
// port-level assertions for the nearest-hit block, bound to the top level
module rsn_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_mode,
    input logic       o_valid,
    input logic       o_hit,
    input logic [1:0] o_hit_slot,
    input logic [7:0] o_out_red,
    input logic [7:0] o_out_green,
    input logic [7:0] o_out_blue
);
    import rsn_pkg::*;

    // a result beat lasts one cycle
    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // a miss reports white and slot zero
    a_miss_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> ((o_hit_slot == 2'd0) && (o_out_red == WHITE) &&
                                 (o_out_green == WHITE) && (o_out_blue == WHITE)))
        else $error("miss result is not white");

    // a trace beat makes the block busy
    a_trace_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == MODE_TRACE)) |=> busy)
        else $error("trace accepted without going busy");

    // a load beat completes at once
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == MODE_LOAD)) |=> !busy)
        else $error("load made the block busy");

    // results only end a trace
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(busy))
        else $error("result without a trace in progress");

endmodule

bind ray_sphere_nearest_hit rsn_check u_rsn_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_mode      (i_mode),
    .o_valid     (o_valid),
    .o_hit       (o_hit),
    .o_hit_slot  (o_hit_slot),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue)
);
